[rtl/ara_pkg.sv]
// Shared types and constants for the address range allocator.
// No dependencies; used by ara_cell and address_range_allocator.
package ara_pkg;

   localparam int DEF_ADDR_BITS  = 48;
   localparam int DEF_PAGE_SIZE  = 4096;
   localparam int DEF_MAX_RANGES = 64;
   localparam int FIELD_W        = 48;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_OVERLAP = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;
   localparam logic [1:0] ST_BEYOND  = 2'd3;

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_CMP  = 3'b010,
      S_DEC  = 3'b100
   } state_type;

   typedef struct packed {
      logic compare;
      logic load_new;
      logic shift;
   } cell_ctrl_type;

endpackage

[rtl/ara_cell.sv]
// One slot of the address map: holds a range and compares it against the request.
// Depends on ara_pkg; instantiated in a row by address_range_allocator.
module ara_cell import ara_pkg::*; #(
   parameter int PAGE_SIZE = DEF_PAGE_SIZE,
   parameter int INDEX     = 0,
   parameter int EW        = 49,
   parameter int CW        = 7
) (
   input  logic               clock,
   input  cell_ctrl_type      ctrl,
   input  logic [FIELD_W-1:0] size,
   input  logic [FIELD_W-1:0] loc,
   input  logic [EW-1:0]      new_base,
   input  logic [CW-1:0]      count,
   input  logic [EW-1:0]      prev_base,
   input  logic [FIELD_W-1:0] prev_len,
   input  logic [EW-1:0]      prev_end,
   output logic [EW-1:0]      base,
   output logic [FIELD_W-1:0] len,
   output logic [EW-1:0]      range_end,
   output logic               occ,
   output logic               sel,
   output logic               lo,
   output logic               hi,
   output logic [EW-1:0]      sub
);

   logic [EW-1:0]      base_ff, base_in;
   logic [FIELD_W-1:0] len_ff, len_in;
   logic               sel_ff, sel_in, lo_ff, lo_in, hi_ff, hi_in;
   logic [EW-1:0]      sub_ff, sub_in;
   logic [EW-1:0]      size_x, loc_x, gap, page;
   logic               fit;

   always_comb begin
      size_x    = EW'(size);
      loc_x     = EW'(loc);
      page      = EW'(PAGE_SIZE);
      range_end = base_ff + EW'(len_ff);
      occ       = (CW'(INDEX) < count);
      gap       = (base_ff >= prev_end) ? (base_ff - prev_end) : '0;
      if (INDEX == 0) begin
         fit = (base_ff >= page) && ((base_ff - page) >= size_x);
      end else begin
         fit = (gap >= size_x);
      end
      // free request looks for a fitting gap, fixed one for the first base at or above
      sel_in  = occ && ((loc == '0) ? fit : (base_ff >= loc_x));
      lo_in   = occ && (range_end > loc_x);
      hi_in   = base_ff < (loc_x + size_x);
      sub_in  = base_ff - size_x;
      base_in = base_ff;
      len_in  = len_ff;
      if (ctrl.load_new) begin
         base_in = new_base;
         len_in  = size;
      end else if (ctrl.shift) begin
         base_in = prev_base;
         len_in  = prev_len;
      end
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
      len_ff  <= len_in;
      if (ctrl.compare) begin
         sel_ff <= sel_in;
         lo_ff  <= lo_in;
         hi_ff  <= hi_in;
         sub_ff <= sub_in;
      end
   end

   assign base = base_ff;
   assign len  = len_ff;
   assign sel  = sel_ff;
   assign lo   = lo_ff;
   assign hi   = hi_ff;
   assign sub  = sub_ff;

endmodule

[rtl/address_range_allocator.sv]
// Top level of the address range allocator: request/response handshake, control, cell row.
// Depends on ara_pkg and ara_cell.
// First-fit allocator over one sorted map of up to MAX_RANGES ranges. A request passes
// through the states IDLE, whose cycle accepts it, CMP, in which every cell compares its
// range with the request in parallel, and DEC, which picks the first match, shifts the
// row to insert the new range and registers the response; req_stall stays high, so no new
// request is taken until the last one has left DEC and the block is back in IDLE. A
// stalled response does not block acceptance, but the decision cycle of the next request
// holds until the response register frees up, and so does the acceptance after it.
// Status: 0 ok, 1 overlap, 2 map full, 3 end beyond 2^ADDR_BITS; base is zero on failure.
module address_range_allocator import ara_pkg::*; #(
   parameter int ADDR_BITS  = DEF_ADDR_BITS,
   parameter int PAGE_SIZE  = DEF_PAGE_SIZE,
   parameter int MAX_RANGES = DEF_MAX_RANGES
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [FIELD_W-1:0] req_size,
   input  logic [FIELD_W-1:0] req_location,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic [FIELD_W-1:0] rsp_granted_base
);

   localparam int EW = ((ADDR_BITS > FIELD_W) ? ADDR_BITS : FIELD_W) + 1;
   localparam int CW = $clog2(MAX_RANGES + 1);
   localparam int N  = MAX_RANGES;

   state_type          state_ff, state_in;
   logic [CW-1:0]      count_ff, count_in;
   logic [FIELD_W-1:0] size_ff, size_in, loc_ff, loc_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [1:0]         status_ff, status_in;
   logic [FIELD_W-1:0] gbase_ff, gbase_in;

   logic [EW-1:0]      c_base [N];
   logic [FIELD_W-1:0] c_len  [N];
   logic [EW-1:0]      c_end  [N];
   logic [EW-1:0]      c_sub  [N];
   logic [N-1:0]       occ, sel, lo, hi, first, at, last_before, last_occ, below;
   logic [N:0]         pre;
   cell_ctrl_type      ctrl [N];

   logic               found, fixed, ovl, beyond, ok, can_out;
   logic [EW-1:0]      new_base, sel_sub, app_end, limit;
   logic [EW:0]        top;

   assign limit = EW'(1) << ADDR_BITS;

   genvar g;
   generate
      for (g = 0; g < N; g++) begin : gen_cell
         ara_cell #(
            .PAGE_SIZE(PAGE_SIZE), .INDEX(g), .EW(EW), .CW(CW)
         ) u_cell (
            .clock     (clock),
            .ctrl      (ctrl[g]),
            .size      (size_ff),
            .loc       (loc_ff),
            .new_base  (new_base),
            .count     (count_ff),
            .prev_base ((g == 0) ? '0 : c_base[(g == 0) ? 0 : g-1]),
            .prev_len  ((g == 0) ? '0 : c_len[(g == 0) ? 0 : g-1]),
            .prev_end  ((g == 0) ? '0 : c_end[(g == 0) ? 0 : g-1]),
            .base      (c_base[g]),
            .len       (c_len[g]),
            .range_end (c_end[g]),
            .occ       (occ[g]),
            .sel       (sel[g]),
            .lo        (lo[g]),
            .hi        (hi[g]),
            .sub       (c_sub[g])
         );
      end
   endgenerate

   always_comb begin
      pre[0] = 1'b0;
      for (int i = 0; i < N; i++) begin
         pre[i+1] = pre[i] | sel[i];
      end
      found   = pre[N];
      sel_sub = '0;
      app_end = '0;
      ovl     = 1'b0;
      for (int i = 0; i < N; i++) begin
         first[i] = sel[i] & ~pre[i];
         at[i]    = first[i] | (~found & (count_ff == CW'(i)));
         below[i] = occ[i] & ~sel[i];
      end
      for (int i = 0; i < N; i++) begin
         last_before[i] = below[i] & ~((i + 1 < N) ? below[(i + 1 < N) ? i+1 : i] : 1'b0);
         last_occ[i]    = occ[i] & ~((i + 1 < N) ? occ[(i + 1 < N) ? i+1 : i] : 1'b0);
         sel_sub = sel_sub | (first[i] ? c_sub[i] : '0);
         app_end = app_end | (last_occ[i] ? c_end[i] : '0);
         ovl     = ovl | (last_before[i] & lo[i]) | (first[i] & hi[i]);
      end
      fixed = (loc_ff != '0);
      if (fixed) begin
         new_base = EW'(loc_ff);
      end else if (count_ff == '0) begin
         new_base = EW'(PAGE_SIZE);
      end else if (found) begin
         new_base = sel_sub;
      end else begin
         new_base = app_end;
      end
      top    = {1'b0, new_base} + (EW+1)'(size_ff);
      beyond = (new_base >= limit) || (top > {1'b0, limit});
      if (count_ff >= CW'(MAX_RANGES)) begin
         status_in = ST_FULL;
      end else if (fixed && ovl) begin
         status_in = ST_OVERLAP;
      end else if (beyond) begin
         status_in = ST_BEYOND;
      end else begin
         status_in = ST_OK;
      end
      ok       = (status_in == ST_OK);
      gbase_in = ok ? new_base[FIELD_W-1:0] : '0;
   end

   always_comb begin
      can_out      = ~rsp_valid_ff | ~rsp_stall;
      state_in     = state_ff;
      count_in     = count_ff;
      size_in      = size_ff;
      loc_in       = loc_ff;
      rsp_valid_in = rsp_valid_ff & rsp_stall;
      for (int i = 0; i < N; i++) begin
         ctrl[i] = '0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               size_in  = req_size;
               loc_in   = req_location;
               state_in = S_CMP;
            end
         end
         S_CMP: begin
            for (int i = 0; i < N; i++) begin
               ctrl[i].compare = 1'b1;
            end
            state_in = S_DEC;
         end
         S_DEC: begin
            // hold until the response register frees up
            if (can_out) begin
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
               if (ok) begin
                  count_in = count_ff + CW'(1);
                  for (int i = 0; i < N; i++) begin
                     ctrl[i].load_new = at[i];
                     ctrl[i].shift    = pre[i];
                  end
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      size_ff <= size_in;
      loc_ff  <= loc_in;
      if (state_ff == S_DEC && can_out) begin
         status_ff <= status_in;
         gbase_ff  <= gbase_in;
      end
   end

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_granted_base = gbase_ff;

endmodule

[sim/address_range_allocator_checker.sv]
// Checker for the address range allocator: watches both channels, predicts each response.
// Depends on ara_pkg for the status codes and field width.
`timescale 1ns / 1ps
module address_range_allocator_checker import ara_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [FIELD_W-1:0] req_size,
   input  logic [FIELD_W-1:0] req_location,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic [1:0]         rsp_status,
   input  logic [FIELD_W-1:0] rsp_granted_base,
   output int                 mismatches,
   output int                 pending,
   output int                 granted_count,
   output int                 refused_count
);

   localparam logic [63:0] ADDR_MASK = (64'd1 << DEF_ADDR_BITS) - 64'd1;
   localparam logic [63:0] PAGE      = 64'(DEF_PAGE_SIZE);

   typedef struct packed {
      logic [1:0]         status;
      logic [FIELD_W-1:0] base;
   } grant_type;

   logic [63:0] map_base [DEF_MAX_RANGES];
   logic [63:0] map_len  [DEF_MAX_RANGES];
   int          map_count;
   grant_type   grant_q [$];

   function automatic bit past_top(logic [63:0] b, logic [63:0] s);
      if (b > ADDR_MASK) return 1'b1;
      if (s == 64'd0) return 1'b0;
      return (s - 64'd1) > (ADDR_MASK - b);
   endfunction

   // Place one range in the shadow map and return the grant it earns.
   function automatic grant_type place_range(logic [63:0] sz, logic [63:0] loc);
      grant_type   g;
      logic [63:0] b;
      logic [63:0] pe;
      int          pos;
      int          n;
      g = '0;
      b = 64'd0;
      pos = 0;
      n = map_count;
      if (n >= DEF_MAX_RANGES) begin
         g.status = ST_FULL;
         return g;
      end
      if (loc == 64'd0) begin
         if (n == 0) begin
            b = PAGE;
         end else if (map_base[0] >= PAGE && map_base[0] - PAGE >= sz) begin
            b = map_base[0] - sz;
         end else begin
            pos = n;
            for (int i = 1; i < n; i++) begin
               pe = map_base[i-1] + map_len[i-1];
               if ((map_base[i] >= pe ? map_base[i] - pe : 64'd0) >= sz) begin
                  pos = i;
                  break;
               end
            end
            if (pos < n) b = map_base[pos] - sz;
            else b = map_base[n-1] + map_len[n-1];
         end
      end else begin
         b = loc;
         pos = n;
         for (int i = 0; i < n; i++) begin
            if (map_base[i] >= loc) begin
               pos = i;
               break;
            end
         end
         if ((pos > 0 && map_base[pos-1] + map_len[pos-1] > loc) ||
             (pos < n && map_base[pos] < loc + sz)) begin
            g.status = ST_OVERLAP;
            return g;
         end
      end
      if (past_top(b, sz)) begin
         g.status = ST_BEYOND;
         return g;
      end
      for (int i = n; i > pos; i--) begin
         map_base[i] = map_base[i-1];
         map_len[i]  = map_len[i-1];
      end
      map_base[pos] = b;
      map_len[pos]  = sz;
      map_count = n + 1;
      g.status = ST_OK;
      g.base   = b[FIELD_W-1:0];
      return g;
   endfunction

   assign pending = grant_q.size();

   always @(posedge clock) begin
      grant_type g;
      if (reset) begin
         map_count = 0;
         grant_q.delete();
         mismatches <= 0;
         granted_count <= 0;
         refused_count <= 0;
      end else begin
         if (req_valid && !req_stall) grant_q.push_back(place_range(64'(req_size),
                                                                    64'(req_location)));
         if (rsp_valid && !rsp_stall) begin
            if (grant_q.size() == 0) begin
               mismatches <= mismatches + 1;
               if (mismatches < 10)
                  $display("%0t: response with no request pending: status %0d base %h",
                           $realtime, rsp_status, rsp_granted_base);
            end else begin
               g = grant_q.pop_front();
               if (g.status == ST_OK) granted_count <= granted_count + 1;
               else refused_count <= refused_count + 1;
               if (g.status !== rsp_status || g.base !== rsp_granted_base) begin
                  mismatches <= mismatches + 1;
                  if (mismatches < 10)
                     $display({"%0t: mismatch: expected status %0d base %h, ",
                               "got status %0d base %h"},
                              $realtime, g.status, g.base, rsp_status, rsp_granted_base);
               end
            end
         end
      end
   end

endmodule

[sim/address_range_allocator_tb.sv]
// Testbench top for the address range allocator: clock, reset, request and response traffic.
// Depends on ara_pkg, address_range_allocator and address_range_allocator_checker.
`timescale 1ns / 1ps
module address_range_allocator_tb;
   import ara_pkg::*;

   localparam int RANDOM_REQS = 1500;
   localparam logic [FIELD_W-1:0] TOP = '1;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [FIELD_W-1:0] req_size = '0;
   logic [FIELD_W-1:0] req_location = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b1;
   logic [1:0]         rsp_status;
   logic [FIELD_W-1:0] rsp_granted_base;
   int                 mismatches, pending, granted_count, refused_count;
   bit                 busy_mode = 1'b1;
   int                 sent = 0;

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   address_range_allocator dut (.*);
   address_range_allocator_checker checker_i (.*);

   function automatic int pick_wait();
      return busy_mode ? $urandom_range(0, 16) : 0;
   endfunction

   // Hold the transaction until the allocator takes it.
   task automatic send_request(logic [FIELD_W-1:0] sz, logic [FIELD_W-1:0] loc);
      int gap;
      gap = pick_wait();
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid = 1'b1;
      req_size = sz;
      req_location = loc;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
      req_valid = 1'b0;
      sent++;
      if (sent % 100 == 0) busy_mode = ($urandom_range(0, 3) != 0);
   endtask

   initial begin
      int n;
      forever begin
         n = pick_wait();
         rsp_stall = 1'b1;
         repeat (n) @(negedge clock);
         rsp_stall = 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   initial begin
      logic [FIELD_W-1:0] sz, loc;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // empty map, zero size, page-gap, overlap and top-of-range cases
      send_request(48'd0, 48'd0);
      send_request(48'h1000, 48'd0);
      send_request(48'h100, 48'h8000);
      send_request(48'h100, 48'h8080);
      send_request(48'h100, 48'h7f80);
      send_request(48'h80, 48'h7f80);
      send_request(48'h10, 48'd0);
      send_request(48'h100, 48'h20000);
      send_request(48'h1000, 48'd0);
      send_request(48'd1, TOP);
      send_request(48'd2, TOP - 48'd1);
      send_request(TOP, 48'd1);
      send_request(TOP, 48'd0);
      send_request(48'd1, 48'd1);
      send_request(48'd0, 48'h8000);
      send_request(48'd0, 48'h8100);
      send_request(48'h800, 48'h800);
      send_request(48'h400, 48'd0);

      repeat (RANDOM_REQS) begin
         loc = '0;
         case ($urandom_range(0, 9))
            0, 1: sz = 48'($urandom_range(0, 16'hffff));
            2, 3, 4: begin
               sz  = 48'($urandom_range(0, 16'h3fff));
               loc = 48'($urandom_range(1, 20'hfffff));
            end
            5: sz = TOP - 48'($urandom_range(0, 16'hffff));
            6: begin
               sz  = 48'($urandom_range(0, 16'hffff));
               loc = TOP - 48'($urandom_range(0, 16'hffff));
            end
            default: begin
               sz  = 48'({$urandom, $urandom});
               loc = 48'({$urandom, $urandom});
               if ($urandom_range(0, 1)) sz = sz >> $urandom_range(0, 47);
            end
         endcase
         send_request(sz, loc);
      end

      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Sent %0d requests: %0d ranges granted, %0d refused (overlap, full, range).",
               sent, granted_count, refused_count);
      if (mismatches == 0) begin
         $display("address_range_allocator_tb: PASS");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("address_range_allocator_tb: FAIL");
      end
      $finish;
   end

   initial begin
      #20ms;
      $display("address_range_allocator_tb: FAIL");
      $finish;
   end

endmodule

[sim.f]
rtl/ara_pkg.sv
rtl/ara_cell.sv
rtl/address_range_allocator.sv
sim/address_range_allocator_checker.sv
sim/address_range_allocator_tb.sv
